// ----- design/gbc_pkg.sv -----
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types, constants and microcode program for the GOST block cipher unit.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int unsigned BlockW   = 64;
  localparam int unsigned HalfW    = 32;
  localparam int unsigned NumKeys  = 8;
  localparam int unsigned KeyIdxW  = 3;
  localparam int unsigned NumRows  = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned UpcW     = 4;
  localparam int unsigned RotBits  = 11;

  // Request mode field: the high bit selects the MAC transform.
  localparam logic [1:0] ModeEncrypt = 2'd0;
  localparam logic [1:0] ModeDecrypt = 2'd1;

  typedef enum logic [1:0] {
    OpRoundFwd  = 2'd0,  // eight rounds, keys K0..K7
    OpRoundRev  = 2'd1,  // eight rounds, keys K7..K0
    OpDoneSwap  = 2'd2,  // emit result with halves swapped
    OpDone      = 2'd3   // emit result as is
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [UpcW-1:0] next;
  } uword_t;

  // Program entry points.
  localparam logic [UpcW-1:0] EntryEnc = 4'd0;
  localparam logic [UpcW-1:0] EntryDec = 4'd5;
  localparam logic [UpcW-1:0] EntryMac = 4'd10;

  function automatic uword_t gbc_ucode(input logic [UpcW-1:0] addr);
    uword_t w;
    case (addr)
      // encrypt
      4'd0:    w = '{op: OpRoundFwd, next: 4'd1};
      4'd1:    w = '{op: OpRoundFwd, next: 4'd2};
      4'd2:    w = '{op: OpRoundFwd, next: 4'd3};
      4'd3:    w = '{op: OpRoundRev, next: 4'd4};
      4'd4:    w = '{op: OpDoneSwap, next: 4'd4};
      // decrypt
      4'd5:    w = '{op: OpRoundFwd, next: 4'd6};
      4'd6:    w = '{op: OpRoundRev, next: 4'd7};
      4'd7:    w = '{op: OpRoundRev, next: 4'd8};
      4'd8:    w = '{op: OpRoundRev, next: 4'd9};
      4'd9:    w = '{op: OpDoneSwap, next: 4'd9};
      // MAC transform
      4'd10:   w = '{op: OpRoundFwd, next: 4'd11};
      4'd11:   w = '{op: OpRoundFwd, next: 4'd12};
      4'd12:   w = '{op: OpDone,     next: 4'd12};
      default: w = '{op: OpDone,     next: 4'd0};
    endcase
    return w;
  endfunction

endpackage

// ----- design/gost_block_cipher_unit.sv -----
// ----------------------------------------------------------------------------
// gost_block_cipher_unit
// GOST 28147-89 block cipher core driven by a microcoded round sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries a mode (encrypt, decrypt, MAC transform), a 64-bit
//   block and the 256-bit key in four parts; it is taken on in_valid_i and
//   in_ready_o both high. The result block leaves on out_valid_o/out_ready_i.
//   The substitution rows are written through cfg_we_i/cfg_index_i/cfg_data_i
//   while the unit is idle.
//   Timing: one round per cycle through a single round unit. Encrypt and
//   decrypt run 32 rounds and MAC runs 16, each followed by a final step
//   that emits the result; a new request is taken the cycle after the
//   result is registered.
//   The step count is set by the microcode program: one control word per
//   block of eight rounds, walked by a 3-bit key index counter.
//   Reset clears the substitution rows to zero and leaves the unit idle.
//   When the receiver stalls, the output register holds the result; a
//   following request runs its rounds and then waits in its final step until
//   the output register frees up.
// ----------------------------------------------------------------------------
module gost_block_cipher_unit
  import gbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [BlockW-1:0]   cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [BlockW-1:0]   block_in_i,
  input  logic [BlockW-1:0]   key_part_0_i,
  input  logic [BlockW-1:0]   key_part_1_i,
  input  logic [BlockW-1:0]   key_part_2_i,
  input  logic [BlockW-1:0]   key_part_3_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [BlockW-1:0]   block_out_o
);

  logic [BlockW-1:0]  sbox_q [NumRows];

  logic [HalfW-1:0]   key_q [NumKeys];
  logic [HalfW-1:0]   n1_q, n1_d, n2_q, n2_d;
  logic               busy_q, busy_d;
  logic [UpcW-1:0]    upc_q, upc_d;
  logic [KeyIdxW-1:0] kidx_q, kidx_d;
  logic               out_valid_q, out_valid_d;
  logic [BlockW-1:0]  out_q, out_d;

  uword_t             uw;
  logic [KeyIdxW-1:0] key_sel;
  logic [HalfW-1:0]   sum, sub, rot, round_out;
  logic               accept, emit;

  // Configuration rows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRows; i++) begin
        sbox_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      sbox_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // Round datapath
  assign uw      = gbc_ucode(upc_q);
  assign key_sel = (uw.op == OpRoundRev) ? ~kidx_q : kidx_q;
  assign sum     = n1_q + key_q[key_sel];

  always_comb begin
    for (int i = 0; i < NumRows; i++) begin
      sub[4*i +: 4] = sbox_q[i][{sum[4*i +: 4], 2'b00} +: 4];
    end
  end

  assign rot       = {sub[HalfW-RotBits-1:0], sub[HalfW-1:HalfW-RotBits]};
  assign round_out = rot ^ n2_q;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // Sequencer
  always_comb begin
    busy_d      = busy_q;
    upc_d       = upc_q;
    kidx_d      = kidx_q;
    n1_d        = n1_q;
    n2_d        = n2_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    emit        = 1'b0;

    if (accept) begin
      busy_d = 1'b1;
      kidx_d = '0;
      n1_d   = block_in_i[HalfW-1:0];
      n2_d   = block_in_i[BlockW-1:HalfW];
      if (mode_i[1]) begin
        upc_d = EntryMac;
      end else if (mode_i == ModeDecrypt) begin
        upc_d = EntryDec;
      end else begin
        upc_d = EntryEnc;
      end
    end else if (busy_q) begin
      case (uw.op)
        OpRoundFwd, OpRoundRev: begin
          n1_d   = round_out;
          n2_d   = n1_q;
          kidx_d = kidx_q + 1'b1;
          if (kidx_q == KeyIdxW'(NumKeys - 1)) begin
            upc_d = uw.next;
          end
        end
        OpDoneSwap, OpDone: begin
          // hold until the output register is free
          emit = !out_valid_q || out_ready_i;
          if (emit) begin
            out_d       = (uw.op == OpDoneSwap) ? {n1_q, n2_q} : {n2_q, n1_q};
            out_valid_d = 1'b1;
            busy_d      = 1'b0;
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      upc_q       <= '0;
      kidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      upc_q       <= upc_d;
      kidx_q      <= kidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_q  <= n1_d;
    n2_q  <= n2_d;
    out_q <= out_d;
    if (accept) begin
      key_q[0] <= key_part_0_i[HalfW-1:0];
      key_q[1] <= key_part_0_i[BlockW-1:HalfW];
      key_q[2] <= key_part_1_i[HalfW-1:0];
      key_q[3] <= key_part_1_i[BlockW-1:HalfW];
      key_q[4] <= key_part_2_i[HalfW-1:0];
      key_q[5] <= key_part_2_i[BlockW-1:HalfW];
      key_q[6] <= key_part_3_i[HalfW-1:0];
      key_q[7] <= key_part_3_i[BlockW-1:HalfW];
    end
  end

  assign out_valid_o = out_valid_q;
  assign block_out_o = out_q;

endmodule

// ----- verif/tb_gost_block_cipher_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gost_block_cipher_unit
// Self-checking bench for the GOST block cipher unit: a behavioral round
// model predicts each result block from the request and the loaded
// substitution rows, and every returned block is compared in order.
// ----------------------------------------------------------------------------
module tb_gost_block_cipher_unit;
  import gbc_pkg::*;

  localparam logic [1:0]  ModeMac     = 2'd2;
  localparam logic [1:0]  ModeMacHigh = 2'd3;  // high bit decodes as MAC too
  localparam int unsigned GapPct      = 16;
  localparam int unsigned SettleCyc   = 40;
  localparam int unsigned CycleLimit  = 250000;
  localparam int unsigned MaxPrinted  = 40;

  typedef logic [HalfW-1:0]  word_t;
  typedef logic [BlockW-1:0] block_t;
  typedef logic [4*BlockW-1:0] key_t;  // {part3, part2, part1, part0}

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [BlockW-1:0]  cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [1:0]         mode_i;
  logic [BlockW-1:0]  block_in_i;
  logic [BlockW-1:0]  key_part_0_i;
  logic [BlockW-1:0]  key_part_1_i;
  logic [BlockW-1:0]  key_part_2_i;
  logic [BlockW-1:0]  key_part_3_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [BlockW-1:0]  block_out_o;

  block_t      sbox_rows [NumRows];
  block_t      expected_blocks [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = GapPct;
  int unsigned stall_left = 0;

  gost_block_cipher_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .block_in_i   (block_in_i),
    .key_part_0_i (key_part_0_i),
    .key_part_1_i (key_part_1_i),
    .key_part_2_i (key_part_2_i),
    .key_part_3_i (key_part_3_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .block_out_o  (block_out_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Round model
  // ---------------------------------------------------------------------------
  function automatic word_t substitute_word(input word_t x);
    word_t       r;
    logic [3:0]  nib;
    r = '0;
    for (int i = 0; i < NumRows; i++) begin
      nib = x[4*i +: 4];
      r[4*i +: 4] = sbox_rows[i][4*nib +: 4];
    end
    return r;
  endfunction

  function automatic word_t round_mix(input word_t n1, input word_t k);
    word_t s;
    s = substitute_word(n1 + k);
    return (s << RotBits) | (s >> (HalfW - RotBits));
  endfunction

  function automatic block_t gost_transform(input logic [1:0] mode, input block_t blk,
                                            input key_t key);
    word_t       n1;
    word_t       n2;
    word_t       t;
    int unsigned steps;
    int unsigned ki;
    n1 = blk[HalfW-1:0];
    n2 = blk[BlockW-1:HalfW];
    steps = mode[1] ? 2 * NumKeys : 4 * NumKeys;
    for (int s = 0; s < steps; s++) begin
      if (mode[1]) begin
        ki = s % NumKeys;
      end else if (mode == ModeEncrypt) begin
        ki = (s < 3 * NumKeys) ? s % NumKeys : NumKeys - 1 - s % NumKeys;
      end else begin
        ki = (s < NumKeys) ? s : NumKeys - 1 - s % NumKeys;
      end
      t = n1;
      n1 = round_mix(n1, key[HalfW*ki +: HalfW]) ^ n2;
      n2 = t;
    end
    // final half swap for encrypt and decrypt only
    if (!mode[1]) begin
      t = n1;
      n1 = n2;
      n2 = t;
    end
    return {n2, n1};
  endfunction

  // ---------------------------------------------------------------------------
  // Checking, receiver, watchdog
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input block_t got, input block_t want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("[%0t] %s: got %h expected %h", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch("result with no pending request", block_out_o, 'x);
      end else if (block_out_o !== expected_blocks[0]) begin
        report_mismatch("block_out", block_out_o, expected_blocks[0]);
        void'(expected_blocks.pop_front());
      end else begin
        void'(expected_blocks.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i = 1'b0;
      stall_left--;
    end else begin
      out_ready_i = ($urandom_range(99) >= gap_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver tasks
  // ---------------------------------------------------------------------------
  function automatic block_t rand_block();
    return {$urandom, $urandom};
  endfunction

  // Mostly random, now and then an extreme value.
  function automatic block_t pick_block();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return rand_block();
    endcase
  endfunction

  function automatic key_t pick_key();
    return {pick_block(), pick_block(), pick_block(), pick_block()};
  endfunction

  task automatic send_request(input logic [1:0] mode, input block_t blk, input key_t key);
    @(negedge clk_i);
    if ($urandom_range(99) < gap_pct) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    mode_i       = mode;
    block_in_i   = blk;
    key_part_0_i = key[0*BlockW +: BlockW];
    key_part_1_i = key[1*BlockW +: BlockW];
    key_part_2_i = key[2*BlockW +: BlockW];
    key_part_3_i = key[3*BlockW +: BlockW];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_blocks.push_back(gost_transform(mode, blk, key));
  endtask

  // Drop valid, wait for every pending result, then let the unit settle.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic program_rows();
    for (int row = 0; row < NumRows; row++) begin
      @(negedge clk_i);
      cfg_we_i    = 1'b1;
      cfg_index_i = row[CfgIdxW-1:0];
      cfg_data_i  = sbox_rows[row];
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_uniform_rows(input block_t value);
    foreach (sbox_rows[i]) sbox_rows[i] = value;
    program_rows();
  endtask

  task automatic load_random_rows();
    foreach (sbox_rows[i]) sbox_rows[i] = rand_block();
    program_rows();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Cleared rows substitute to zero, so every round just exchanges the halves.
  task automatic test_cleared_rows();
    send_request(ModeEncrypt, rand_block(), pick_key());
    send_request(ModeDecrypt, rand_block(), pick_key());
    send_request(ModeMac, rand_block(), pick_key());
    send_request(ModeMacHigh, rand_block(), pick_key());
    drain();
  endtask

  task automatic test_field_extremes();
    block_t ct;
    key_t   key;
    load_uniform_rows(64'hFEDC_BA98_7654_3210);
    send_request(ModeEncrypt, '0, '0);
    send_request(ModeDecrypt, '0, '0);
    send_request(ModeMac, '0, '0);
    send_request(ModeMacHigh, '0, '0);
    send_request(ModeEncrypt, '1, '1);
    send_request(ModeDecrypt, '1, '1);
    send_request(ModeMacHigh, '1, '1);
    // sum wraps past 2^32 on the first round
    send_request(ModeEncrypt, 64'h0000_0001_FFFF_FFFF, {8{32'h0000_0001}});
    send_request(ModeDecrypt, 64'h0000_0001_FFFF_FFFF, {8{32'hFFFF_FFFF}});
    send_request(ModeMac, 64'h8000_0000_8000_0000, {8{32'h8000_0000}});
    drain();
    load_random_rows();
    key = pick_key();
    ct = gost_transform(ModeEncrypt, 64'h0123_4567_89AB_CDEF, key);
    send_request(ModeEncrypt, 64'h0123_4567_89AB_CDEF, key);
    send_request(ModeDecrypt, ct, key);
    send_request(ModeMac, ct, key);
    drain();
    load_uniform_rows('1);
    send_request(ModeEncrypt, rand_block(), pick_key());
    send_request(ModeDecrypt, rand_block(), pick_key());
    send_request(ModeMac, rand_block(), pick_key());
    drain();
  endtask

  // Hold the receiver off while requests keep coming, so the input stalls.
  task automatic test_output_backpressure();
    load_random_rows();
    @(posedge clk_i);
    stall_left = 300;
    repeat (10) send_request(2'($urandom_range(3)), rand_block(), pick_key());
    drain();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      if (phase == 3) begin
        load_uniform_rows('0);
      end else begin
        load_random_rows();
      end
      gap_pct = (phase == 2) ? 0 : GapPct;
      repeat (100) send_request(2'($urandom_range(3)), pick_block(), pick_key());
      drain();
    end
    gap_pct = GapPct;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    mode_i       = ModeEncrypt;
    block_in_i   = '0;
    key_part_0_i = '0;
    key_part_1_i = '0;
    key_part_2_i = '0;
    key_part_3_i = '0;
    out_ready_i  = 1'b0;
    foreach (sbox_rows[i]) sbox_rows[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_cleared_rows();
    test_field_extremes();
    test_output_backpressure();
    test_random_traffic();

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
